// File: rtl/branch_resolve_local_predictor_unit_assert.svh
// Assertion macros used by the checker module of this block.
`ifndef BRANCH_RESOLVE_LOCAL_PREDICTOR_UNIT_ASSERT_SVH
`define BRANCH_RESOLVE_LOCAL_PREDICTOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brlp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brlp assertion failed");

`endif

// File: rtl/brlp_pkg.sv
package brlp_pkg;

    // Default table geometry.
    localparam int DEFAULT_TABLE_ENTRIES = 32;
    localparam int DEFAULT_HISTORY_BITS  = 2;

    // Transactions that can be in flight: the execute stage and the result register.
    localparam int PIPE_DEPTH = 2;

    // Sequential fetch step.
    localparam logic [31:0] PC_STEP = 32'd4;

    typedef logic [2:0] branch_kind_t;
    typedef logic [1:0] counter_t;

    // Request actions.
    localparam logic ACTION_PREDICT = 1'b0;
    localparam logic ACTION_RESOLVE = 1'b1;

    // RV32I branch conditions.
    localparam branch_kind_t KIND_EQ  = 3'd0;
    localparam branch_kind_t KIND_NE  = 3'd1;
    localparam branch_kind_t KIND_LT  = 3'd2;
    localparam branch_kind_t KIND_GE  = 3'd3;
    localparam branch_kind_t KIND_LTU = 3'd4;
    localparam branch_kind_t KIND_GEU = 3'd5;

    // Saturating counter limits.
    localparam counter_t CTR_MAX = 2'd3;
    localparam counter_t CTR_MIN = 2'd0;

endpackage

// File: rtl/branch_resolve_local_predictor_unit.sv
// Branch unit with a two-level local predictor.
// The request channel (req_valid/req_ready) carries one transaction per branch:
// action 0 predicts at decode, action 1 resolves at execute with the two operands.
// The response channel (rsp_valid/rsp_ready) returns exactly one transaction per
// request, in order: prediction, actual outcome, mispredict flag and next fetch pc.
// The synchronous table read registers a request into the execute stage; compare,
// update and write-back follow there before the response register. Throughput is
// one transaction per cycle while rsp_ready is high; a resolve to the same entry
// directly after another gets the write-back data forwarded into the read register.
// The table is indexed by pc bits [log2(TABLE_ENTRIES)+1:2]; TABLE_ENTRIES is a
// power of two. History and the row of counters of an entry share one address.
// After reset the block sweeps both memories to zero, one entry per cycle, and
// req_ready stays low during that sweep.
// When the receiver stalls, the response register holds its transaction and the
// execute stage holds one more; after that req_ready drops until rsp_ready returns.
module branch_resolve_local_predictor_unit #(
    parameter int TABLE_ENTRIES = brlp_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int HISTORY_BITS  = brlp_pkg::DEFAULT_HISTORY_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   action,
    input  logic [31:0]            branch_pc,
    input  logic signed [12:0]     branch_offset,
    input  brlp_pkg::branch_kind_t branch_kind,
    input  logic [31:0]            operand_a,
    input  logic [31:0]            operand_b,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic                   predicted_taken,
    output logic                   actual_taken,
    output logic                   mispredict,
    output logic [31:0]            next_pc
);
    import brlp_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int PATTERNS = 1 << HISTORY_BITS;
    localparam int ROW_W    = 2 * PATTERNS;

    // Memories: one history and one row of counters per entry.
    logic [HISTORY_BITS-1:0] hist_mem [TABLE_ENTRIES];
    logic [ROW_W-1:0]        ctr_mem  [TABLE_ENTRIES];

    // Reset sweep.
    logic             clear_reg;
    logic [IDX_W-1:0] clear_cnt_reg;

    // Execute stage.
    logic                    s1_valid_reg;
    logic                    s1_action_reg;
    logic [31:0]             s1_pc_reg;
    logic signed [12:0]      s1_offset_reg;
    branch_kind_t            s1_kind_reg;
    logic [31:0]             s1_a_reg;
    logic [31:0]             s1_b_reg;
    logic [IDX_W-1:0]        s1_idx_reg;
    logic [HISTORY_BITS-1:0] hist_rd_reg;
    logic [ROW_W-1:0]        row_rd_reg;

    // Response register.
    logic        rsp_valid_reg;
    logic        pred_reg;
    logic        actual_reg;
    logic        mispred_reg;
    logic [31:0] next_pc_reg;

    // Handshake and write port.
    logic                    req_fire;
    logic                    s1_adv;
    logic [IDX_W-1:0]        req_idx;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic [HISTORY_BITS-1:0] wr_hist;
    logic [ROW_W-1:0]        wr_row;

    // Execute-stage computation.
    logic [HISTORY_BITS:0]   ctr_base;
    counter_t                ctr_cur;
    counter_t                ctr_new;
    logic                    predicted;
    logic                    outcome;
    logic                    kind_ok;
    logic [31:0]             taken_pc;
    logic [31:0]             fall_pc;
    logic                    res_actual;
    logic                    res_mispred;
    logic [31:0]             res_next_pc;
    logic [HISTORY_BITS-1:0] hist_new;
    logic [ROW_W-1:0]        row_new;

    // Flow control.
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !clear_reg && (!s1_valid_reg || s1_adv);
    assign req_fire  = req_valid && req_ready;
    assign req_idx   = branch_pc[IDX_W+1:2];

    // Outcome, counter update and next pc for the transaction in the execute stage.
    always_comb
    begin
        ctr_base  = {hist_rd_reg, 1'b0};
        ctr_cur   = row_rd_reg[ctr_base +: 2];
        predicted = ctr_cur[1];
        fall_pc   = s1_pc_reg + PC_STEP;
        taken_pc  = s1_pc_reg + {{19{s1_offset_reg[12]}}, s1_offset_reg};
        kind_ok   = 1'b1;
        unique case (s1_kind_reg)
            KIND_EQ:  outcome = (s1_a_reg == s1_b_reg);
            KIND_NE:  outcome = (s1_a_reg != s1_b_reg);
            KIND_LT:  outcome = ($signed(s1_a_reg) < $signed(s1_b_reg));
            KIND_GE:  outcome = ($signed(s1_a_reg) >= $signed(s1_b_reg));
            KIND_LTU: outcome = (s1_a_reg < s1_b_reg);
            KIND_GEU: outcome = (s1_a_reg >= s1_b_reg);
            default:
            begin
                outcome = 1'b0;
                kind_ok = 1'b0;
            end
        endcase

        // Saturate the selected counter toward the outcome.
        if (outcome)
        begin
            ctr_new = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + 2'd1;
        end
        else
        begin
            ctr_new = (ctr_cur == CTR_MIN) ? ctr_cur : ctr_cur - 2'd1;
        end
        row_new                 = row_rd_reg;
        row_new[ctr_base +: 2]  = ctr_new;
        hist_new                = HISTORY_BITS'({hist_rd_reg, outcome});

        if (s1_action_reg == ACTION_RESOLVE)
        begin
            res_actual  = outcome;
            res_mispred = kind_ok && (outcome != predicted);
            res_next_pc = outcome ? taken_pc : fall_pc;
        end
        else
        begin
            res_actual  = 1'b0;
            res_mispred = 1'b0;
            res_next_pc = predicted ? taken_pc : fall_pc;
        end
    end

    // Write port: the reset sweep, else the write-back of a valid resolve.
    always_comb
    begin
        if (clear_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = clear_cnt_reg;
            wr_hist = '0;
            wr_row  = '0;
        end
        else
        begin
            wr_en   = s1_adv && (s1_action_reg == ACTION_RESOLVE) && kind_ok;
            wr_idx  = s1_idx_reg;
            wr_hist = hist_new;
            wr_row  = row_new;
        end
    end

    // Memory write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_idx] <= wr_hist;
            ctr_mem[wr_idx]  <= wr_row;
        end
    end

    // Memory read, with the same-cycle write-back forwarded to the new transaction.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            if (wr_en && (wr_idx == req_idx))
            begin
                hist_rd_reg <= wr_hist;
                row_rd_reg  <= wr_row;
            end
            else
            begin
                hist_rd_reg <= hist_mem[req_idx];
                row_rd_reg  <= ctr_mem[req_idx];
            end
        end
    end

    // Reset sweep control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + IDX_W'(1);
            if (clear_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // Execute-stage and response valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Execute-stage payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_action_reg <= action;
            s1_pc_reg     <= branch_pc;
            s1_offset_reg <= branch_offset;
            s1_kind_reg   <= branch_kind;
            s1_a_reg      <= operand_a;
            s1_b_reg      <= operand_b;
            s1_idx_reg    <= req_idx;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pred_reg    <= predicted;
            actual_reg  <= res_actual;
            mispred_reg <= res_mispred;
            next_pc_reg <= res_next_pc;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign predicted_taken = pred_reg;
    assign actual_taken    = actual_reg;
    assign mispredict      = mispred_reg;
    assign next_pc         = next_pc_reg;

endmodule

// File: rtl/brlp_checker.sv
`include "branch_resolve_local_predictor_unit_assert.svh"

module brlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        predicted_taken,
    input logic        actual_taken,
    input logic        mispredict,
    input logic [31:0] next_pc
);
    import brlp_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_fire;
    logic       rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Count transactions accepted but not yet answered.
    always_comb
    begin
        pending_next = pending_reg;
        if (req_fire && !rsp_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_fire && !req_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A response never appears without an outstanding request.
    `BRLP_ASSERT_IMPLY(a_no_phantom_rsp, clk, rst_n, rsp_valid, pending_reg != 2'd0)

    // The block never holds more transactions than its two stages.
    `BRLP_ASSERT_IMPLY(a_depth_bound, clk, rst_n, 1'b1, pending_reg <= 2'(PIPE_DEPTH))

    // A mispredict always reports an outcome that differs from the prediction.
    `BRLP_ASSERT_IMPLY(a_mispred_consistent, clk, rst_n, rsp_valid && mispredict,
        actual_taken != predicted_taken)

    // A stalled response stays valid and holds its next_pc and mispredict flag.
    `BRLP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(next_pc) && $stable(mispredict))

endmodule

bind branch_resolve_local_predictor_unit brlp_checker u_brlp_checker (.*);

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brlp_pkg::*;

    localparam int CLK_HALF_NS      = 6;
    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_ITEMS     = 900;
    localparam int IDLE_PERCENT     = 25;
    localparam int CALM_FIRST       = 400;
    localparam int CALM_LAST        = 560;
    localparam int HOLD_AT_RESULT   = 200;
    localparam int HOLD_CYCLES      = 80;
    localparam int DRAIN_CYCLES     = 4 * PIPE_DEPTH;
    localparam int LOOP_PCS         = 8;
    localparam int ENTRY_COUNT      = DEFAULT_TABLE_ENTRIES;
    localparam int PATTERNS         = 1 << DEFAULT_HISTORY_BITS;

    // Branch kinds that a resolve treats as no branch at all.
    localparam branch_kind_t KIND_UNUSED_LO = 3'd6;
    localparam branch_kind_t KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic               action;
        logic [31:0]        pc;
        logic signed [12:0] offset;
        branch_kind_t       kind;
        logic [31:0]        op_a;
        logic [31:0]        op_b;
    } branch_req_t;

    typedef struct packed {
        logic        predicted;
        logic        actual;
        logic        mispredict;
        logic [31:0] next_pc;
    } branch_outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic                action = ACTION_PREDICT;
    logic [31:0]         branch_pc = '0;
    logic signed [12:0]  branch_offset = '0;
    branch_kind_t        branch_kind = KIND_EQ;
    logic [31:0]         operand_a = '0;
    logic [31:0]         operand_b = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic                predicted_taken;
    logic                actual_taken;
    logic                mispredict;
    logic [31:0]         next_pc;

    // Mirror of the predictor tables.
    logic [DEFAULT_HISTORY_BITS-1:0] history_mirror [ENTRY_COUNT];
    counter_t                        counter_mirror [ENTRY_COUNT * PATTERNS];

    branch_req_t     branch_requests [$];
    branch_outcome_t expected_outcomes [$];

    int accepted_count = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int predict_count  = 0;
    int resolve_count  = 0;
    int unused_count   = 0;
    int miss_count     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    branch_resolve_local_predictor_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .action         (action),
        .branch_pc      (branch_pc),
        .branch_offset  (branch_offset),
        .branch_kind    (branch_kind),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .predicted_taken(predicted_taken),
        .actual_taken   (actual_taken),
        .mispredict     (mispredict),
        .next_pc        (next_pc)
    );

    // Evaluates an RV32I branch condition; unused kinds are never taken.
    function automatic logic branch_condition(input branch_kind_t kind, input logic [31:0] a,
                                              input logic [31:0] b, output logic known);
        known = 1'b1;
        case (kind)
            KIND_EQ:  return a == b;
            KIND_NE:  return a != b;
            KIND_LT:  return $signed(a) < $signed(b);
            KIND_GE:  return $signed(a) >= $signed(b);
            KIND_LTU: return a < b;
            KIND_GEU: return a >= b;
            default:
            begin
                known = 1'b0;
                return 1'b0;
            end
        endcase
    endfunction

    // Computes the outcome of one accepted transaction and updates the table mirror.
    function automatic branch_outcome_t compute_branch_outcome(input branch_req_t r);
        branch_outcome_t                 o;
        logic [4:0]                      entry;
        logic [DEFAULT_HISTORY_BITS-1:0] hist;
        counter_t                        ctr;
        logic [31:0]                     taken_pc;
        logic [31:0]                     fall_pc;
        logic                            known;
        entry = r.pc[6:2];
        hist = history_mirror[entry];
        ctr = counter_mirror[{entry, hist}];
        taken_pc = r.pc + {{19{r.offset[12]}}, r.offset};
        fall_pc = r.pc + PC_STEP;
        o.predicted = ctr[1];
        if (r.action == ACTION_PREDICT)
        begin
            predict_count++;
            o.actual = 1'b0;
            o.mispredict = 1'b0;
            o.next_pc = o.predicted ? taken_pc : fall_pc;
            return o;
        end
        resolve_count++;
        o.actual = branch_condition(r.kind, r.op_a, r.op_b, known);
        if (known)
        begin
            if (o.actual && ctr != CTR_MAX)
                ctr++;
            else if (!o.actual && ctr != CTR_MIN)
                ctr--;
            counter_mirror[{entry, hist}] = ctr;
            history_mirror[entry] = {hist[DEFAULT_HISTORY_BITS-2:0], o.actual};
        end
        else
            unused_count++;
        o.mispredict = known && (o.actual != o.predicted);
        if (o.mispredict)
            miss_count++;
        o.next_pc = o.actual ? taken_pc : fall_pc;
        return o;
    endfunction

    // Random idle decision, suppressed over a calm window of transactions.
    function automatic bit gap_now(input int count);
        if (count >= CALM_FIRST && count <= CALM_LAST)
            return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    task automatic queue_branch(input logic act, input logic [31:0] pc,
                                input logic signed [12:0] off, input branch_kind_t kind,
                                input logic [31:0] a, input logic [31:0] b);
        branch_requests.push_back('{act, pc, off, kind, a, b});
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    // Operand pair drawn from equal, random, extreme and adjacent values.
    function automatic logic [63:0] draw_operands();
        logic [31:0] corner [5];
        logic [31:0] a;
        logic [31:0] b;
        corner = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        a = $urandom;
        b = $urandom;
        case ($urandom_range(3))
            0: b = a;
            1: ;
            2:
            begin
                a = corner[$urandom_range(4)];
                b = corner[$urandom_range(4)];
            end
            default: b = $urandom_range(1) ? a + 1 : a - 1;
        endcase
        return {a, b};
    endfunction

    // Clock.
    initial
    begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Reset, released once.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus: directed corner cases, then loops with trained patterns plus noise.
    initial
    begin
        logic [31:0]        loop_pc [LOOP_PCS];
        logic signed [12:0] loop_off [LOOP_PCS];
        logic [7:0]         loop_pattern [LOOP_PCS];
        int                 loop_step [LOOP_PCS];
        int                 sel;
        logic [63:0]        ops;
        branch_kind_t       kind;
        logic               want;
        logic               outcome;
        logic               known;
        logic [31:0]        pc;
        logic signed [12:0] off;

        queue_branch(ACTION_PREDICT, 32'h0000_0000, 13'sd4094, KIND_EQ, '0, '0);
        queue_branch(ACTION_RESOLVE, 32'h0000_0000, -13'sd4096, KIND_EQ,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_branch(ACTION_RESOLVE, 32'h0000_0000, 13'sd4094, KIND_NE, 32'h1234, 32'h1234);
        queue_branch(ACTION_RESOLVE, 32'h0000_0010, 13'sd16, KIND_LT,
                     32'h8000_0000, 32'h7FFF_FFFF);
        queue_branch(ACTION_RESOLVE, 32'h0000_0010, 13'sd16, KIND_LTU,
                     32'h8000_0000, 32'h7FFF_FFFF);
        queue_branch(ACTION_RESOLVE, 32'h0000_0010, -13'sd16, KIND_GE,
                     32'h7FFF_FFFF, 32'h8000_0000);
        queue_branch(ACTION_RESOLVE, 32'h0000_0010, -13'sd16, KIND_GEU,
                     32'h0000_0000, 32'hFFFF_FFFF);
        queue_branch(ACTION_RESOLVE, 32'h0000_0014, 13'sd64, KIND_UNUSED_LO, '0, '0);
        queue_branch(ACTION_RESOLVE, 32'h0000_0014, 13'sd64, KIND_UNUSED_HI, '1, '0);
        // Saturate one entry upward with a wrapping target, then downward.
        repeat (6)
            queue_branch(ACTION_RESOLVE, 32'hFFFF_FFFC, 13'sd8, KIND_EQ, 32'h55, 32'h55);
        queue_branch(ACTION_PREDICT, 32'hFFFF_FFFC, 13'sd8, KIND_UNUSED_HI, '1, '1);
        queue_branch(ACTION_RESOLVE, 32'hFFFF_FFFC, 13'sd8, KIND_UNUSED_LO, '0, '0);
        repeat (6)
            queue_branch(ACTION_RESOLVE, 32'hFFFF_FFFC, 13'sd8, KIND_NE, 32'h55, 32'h55);
        queue_branch(ACTION_PREDICT, 32'hFFFF_FFFC, 13'sd8, KIND_EQ, '0, '0);
        queue_branch(ACTION_PREDICT, 32'h0000_007C, 13'sd0, KIND_GEU, '1, '0);

        for (int i = 0; i < LOOP_PCS; i++)
        begin
            loop_pc[i] = $urandom;
            loop_off[i] = {12'($urandom_range(4095)), 1'b0};
            loop_pattern[i] = 8'($urandom);
            loop_step[i] = 0;
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            ops = draw_operands();
            kind = branch_kind_t'($urandom_range(5));
            if ($urandom_range(99) < 80)
            begin
                // A known loop branch: its resolves follow its pattern.
                sel = $urandom_range(LOOP_PCS - 1);
                pc = loop_pc[sel];
                off = loop_off[sel];
                if ($urandom_range(99) < 35)
                    queue_branch(ACTION_PREDICT, pc, off, branch_kind_t'($urandom_range(7)),
                                 ops[63:32], ops[31:0]);
                else
                begin
                    want = loop_pattern[sel][loop_step[sel] % 8];
                    loop_step[sel]++;
                    outcome = branch_condition(kind, ops[63:32], ops[31:0], known);
                    // Each kind pair differs only in bit 0 and has the opposite outcome.
                    if (outcome != want)
                        kind = kind ^ 3'd1;
                    if ($urandom_range(99) < 4)
                        kind = $urandom_range(1) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
                    queue_branch(ACTION_RESOLVE, pc, off, kind, ops[63:32], ops[31:0]);
                end
            end
            else
            begin
                // Noise: any address, any even offset, any kind.
                off = {12'($urandom_range(4095)), 1'b0};
                if ($urandom_range(99) < 10)
                    kind = $urandom_range(1) ? KIND_UNUSED_LO : KIND_UNUSED_HI;
                queue_branch(logic'($urandom_range(1)), $urandom, off, kind,
                             ops[63:32], ops[31:0]);
            end
        end
    end

    // Driver: presents queued transactions, holding each until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        branch_req_t next_req;
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRY_COUNT; e++)
                history_mirror[e] = '0;
            for (int s = 0; s < ENTRY_COUNT * PATTERNS; s++)
                counter_mirror[s] = CTR_MIN;
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_outcomes.push_back(compute_branch_outcome(
                    '{action, branch_pc, branch_offset, branch_kind, operand_a, operand_b}));
                accepted_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (branch_requests.size() > 0 && !gap_now(accepted_count))
                begin
                    next_req = branch_requests.pop_front();
                    req_valid <= 1'b1;
                    action <= next_req.action;
                    branch_pc <= next_req.pc;
                    branch_offset <= next_req.offset;
                    branch_kind <= next_req.kind;
                    operand_a <= next_req.op_a;
                    operand_b <= next_req.op_b;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : collect_results
        branch_outcome_t want;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: response with nothing expected, next_pc %h",
                             $time, next_pc);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    report_field("predicted_taken", 32'(want.predicted), 32'(predicted_taken));
                    report_field("actual_taken", 32'(want.actual), 32'(actual_taken));
                    report_field("mispredict", 32'(want.mispredict), 32'(mispredict));
                    report_field("next_pc", want.next_pc, next_pc);
                end
                results_seen++;
                // Back up the pipeline once with a long receiver stall.
                if (results_seen == HOLD_AT_RESULT && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= !gap_now(results_seen);
        end
    end

    // End of run: drain, let the pipeline settle, then report.
    initial
    begin
        @(posedge rst_n);
        while (branch_requests.size() > 0 || req_valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d predicts and %0d resolves (%0d mispredicted, %0d unused kinds).",
                 predict_count, resolve_count, miss_count, unused_count);
        $display("Responses checked: %0d, including a %0d-cycle receiver stall.",
                 results_seen, HOLD_CYCLES);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("Timeout with %0d responses still expected.", expected_outcomes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/brlp_pkg.sv
rtl/branch_resolve_local_predictor_unit.sv
rtl/brlp_checker.sv
bench/tb_top.sv
